// ===== rtl/core/rwps_pkg.sv =====
// Package for the random walk particle step block: widths, register codes,
// payload types and the command and status types of the controller/datapath pair.
// Depends on nothing; every other file of the block imports it.
package rwps_pkg;

    // Widths of the input samples and of the kept position.
    localparam int SAMPLE_WIDTH = 16;
    localparam int POS_WIDTH    = 32;
    localparam int FRAC_BITS    = 12;

    // Configuration port.
    localparam int SCALE_W     = 16;
    localparam int STEPS_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SCALE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_NUM_STEPS  = CFG_INDEX_W'(1);
    localparam logic [SCALE_W-1:0] STEP_SCALE_RST = SCALE_W'(4096);
    localparam logic [STEPS_W-1:0] NUM_STEPS_RST  = STEPS_W'(100);

    // Direction normalization: the larger magnitude ends in [2^14, 2^15).
    localparam int MAG_W  = 15;
    localparam int NORM_W = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;

    // Square root of the squared norm scaled by 2^32.
    localparam int ROOT_BITS  = 32;
    localparam int RAD_W      = 2 * ROOT_BITS;
    localparam int ROOT_REM_W = ROOT_BITS + 3;
    localparam int RAD_SUM_W  = 2 * MAG_W + 1;

    // Unit vector division.
    localparam int UNIT_FRAC  = 46 - SAMPLE_WIDTH;
    localparam int UNIT_SHIFT = 16 + UNIT_FRAC;
    localparam int QUOT_W     = UNIT_FRAC + 1;
    localparam int NUM_W      = UNIT_FRAC + 32;
    localparam int DIV_REM_W  = ROOT_BITS;

    // Scaled step and displacement.
    localparam int SCALED_W  = SAMPLE_WIDTH + 15;
    localparam int PROD_W    = SCALED_W + QUOT_W;
    localparam int RND_SHIFT = FRAC_BITS + UNIT_FRAC;
    localparam int MOVE_W    = PROD_W + 1 - RND_SHIFT;
    localparam logic [PROD_W:0] RND_HALF = (PROD_W + 1)'(1) << (RND_SHIFT - 1);
    localparam int EXT_W     = ((POS_WIDTH > MOVE_W) ? POS_WIDTH : MOVE_W) + 2;

    // Squared distance.
    localparam int ABS_W = (POS_WIDTH > 32) ? POS_WIDTH : 32;
    localparam int SQ_OP_W = 32;
    localparam int SQ_W  = 2 * SQ_OP_W;
    localparam int DSQ_W = 63;
    localparam logic [ABS_W-1:0] ROOT_MAX = ABS_W'(32'hB504F333);
    localparam logic [SQ_W:0] DSQ_TOP = (SQ_W + 1)'({DSQ_W{1'b1}});

    // Iteration counter of the controller.
    localparam int ITER_MAX = (ROOT_BITS > QUOT_W) ? ROOT_BITS : QUOT_W;
    localparam int CNT_W    = $clog2(ITER_MAX);

    // One input item.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] gauss_mag;
        logic signed [SAMPLE_WIDTH-1:0] gauss_dir_x;
        logic signed [SAMPLE_WIDTH-1:0] gauss_dir_y;
    } rwps_in_t;

    // One result item.
    typedef struct packed {
        logic signed [POS_WIDTH-1:0] pos_x;
        logic signed [POS_WIDTH-1:0] pos_y;
        logic [DSQ_W-1:0]            disp_sq;
        logic [STEPS_W-1:0]          step_index;
        logic                        last_step;
        logic                        no_move;
    } rwps_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic norm_shift;
        logic sq_sum;
        logic root_step;
        logic div_init;
        logic div_step;
        logic mul_x;
        logic mul_y;
        logic rnd_y;
        logic pos_upd;
        logic abs_calc;
        logic sq_x;
        logic sq_y;
        logic disp_sum;
        logic out_load;
    } rwps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic zero_dir;
        logic norm_done;
    } rwps_stat_t;

endpackage

// ===== rtl/core/rwps_ctrl.sv =====
// Controller of the random walk particle step block: the sequencing state
// machine, the iteration counter and the valid bit of the output register.
// Depends on rwps_pkg.
module rwps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    output logic                 result_valid,
    input  logic                 result_stall,
    input  rwps_pkg::rwps_stat_t stat,
    output rwps_pkg::rwps_cmd_t  cmd
);
    import rwps_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_NORM  = 4'd1;
    localparam logic [3:0] S_SQSUM = 4'd2;
    localparam logic [3:0] S_ROOT  = 4'd3;
    localparam logic [3:0] S_DINIT = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_MULX  = 4'd6;
    localparam logic [3:0] S_MULY  = 4'd7;
    localparam logic [3:0] S_RNDY  = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_ABS   = 4'd10;
    localparam logic [3:0] S_SQX   = 4'd11;
    localparam logic [3:0] S_SQY   = 4'd12;
    localparam logic [3:0] S_SUM   = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = out_valid_reg;

    // Next state, counter and commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;

        // The waiting result leaves when the consumer takes it.
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (stat.zero_dir)
                begin
                    state_next = S_ABS;
                end
                else if (stat.norm_done)
                begin
                    state_next = S_SQSUM;
                end
                else
                begin
                    cmd.norm_shift = 1'b1;
                end
            end
            S_SQSUM:
            begin
                cmd.sq_sum = 1'b1;
                cnt_next   = CNT_W'(ROOT_BITS - 1);
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DINIT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = CNT_W'(QUOT_W - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_MULX;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_MULX:
            begin
                cmd.mul_x  = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_y  = 1'b1;
                state_next = S_RNDY;
            end
            S_RNDY:
            begin
                cmd.rnd_y  = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.pos_upd = 1'b1;
                state_next  = S_ABS;
            end
            S_ABS:
            begin
                cmd.abs_calc = 1'b1;
                state_next   = S_SQX;
            end
            S_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = S_SQY;
            end
            S_SQY:
            begin
                cmd.sq_y   = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.disp_sum = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // Load the output register once it is free or being emptied.
                if (!out_valid_reg || !result_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/rwps_datapath.sv =====
// Datapath of the random walk particle step block: sample capture, direction
// normalization, bit-serial square root and division, scaling, position and distance.
// Depends on rwps_pkg; driven by the commands of rwps_ctrl.
module rwps_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rwps_pkg::rwps_cmd_t          cmd,
    output rwps_pkg::rwps_stat_t         stat,
    input  rwps_pkg::rwps_in_t           sample,
    input  logic [rwps_pkg::SCALE_W-1:0] step_scale,
    input  logic [rwps_pkg::STEPS_W-1:0] num_steps,
    output rwps_pkg::rwps_out_t          result
);
    import rwps_pkg::*;

    // Walk state.
    logic signed [POS_WIDTH-1:0] cur_x_reg, cur_y_reg;
    logic [STEPS_W-1:0]          step_cnt_reg;

    // Captured item.
    logic [SAMPLE_WIDTH-1:0] mm_reg;
    logic [NORM_W-1:0]       na_reg, nb_reg;
    logic                    mneg_reg, xneg_reg, yneg_reg, zero_reg, last_reg;

    // Square root, division and scaling.
    logic [RAD_W-1:0]      rad_reg;
    logic [ROOT_REM_W-1:0] root_rem_reg;
    logic [ROOT_BITS-1:0]  root_reg;
    logic [DIV_REM_W-1:0]  rem_x_reg, rem_y_reg;
    logic [QUOT_W-1:0]     quot_x_reg, quot_y_reg;
    logic [SCALED_W-1:0]   s_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [MOVE_W-1:0]     dx_reg, dy_reg;

    // Distance.
    logic [SQ_OP_W-1:0] ax_reg, ay_reg;
    logic               big_reg;
    logic [SQ_W-1:0]    sq_reg, acc_reg;
    logic [DSQ_W-1:0]   disp_reg;
    rwps_out_t          result_reg;

    // Combinational terms.
    logic [SAMPLE_WIDTH-1:0] mag_m, mag_x, mag_y;
    logic [STEPS_W-1:0]      walk, cnt_new;
    logic                    restart;
    logic [NORM_W-1:0]       norm_or;
    logic [RAD_SUM_W-1:0]    rad_sum;
    logic [SCALE_W+SAMPLE_WIDTH-1:0] scale_prod;
    logic [ROOT_REM_W-1:0]   root_sh, root_trial;
    logic                    root_fit;
    logic [NUM_W-1:0]        num_x, num_y;
    logic [DIV_REM_W:0]      div_sh_x, div_sh_y, div_den;
    logic                    fit_x, fit_y;
    logic [QUOT_W-1:0]       mul_b;
    logic [PROD_W-1:0]       prod_next;
    logic [PROD_W:0]         rnd_sum;
    logic [POS_WIDTH-1:0]    neg_x, neg_y, abs_x, abs_y;
    logic [ABS_W-1:0]        abs_x_ext, abs_y_ext;
    logic [SQ_OP_W-1:0]      sq_op;
    logic [SQ_W-1:0]         sq_prod;
    logic [SQ_W:0]           dsq_sum;

    // Adds a move to a position and clamps to the position range.
    function automatic logic signed [POS_WIDTH-1:0] sat_add(
        input logic signed [POS_WIDTH-1:0] p,
        input logic [MOVE_W-1:0]           d,
        input logic                        neg
    );
        logic [EXT_W-1:0]           pe, de, se;
        logic [EXT_W-POS_WIDTH:0]   upper;
        logic signed [POS_WIDTH-1:0] r;
        pe    = {{(EXT_W - POS_WIDTH){p[POS_WIDTH-1]}}, p};
        de    = {{(EXT_W - MOVE_W){1'b0}}, d};
        se    = neg ? (pe - de) : (pe + de);
        upper = se[EXT_W-1:POS_WIDTH-1];
        if (upper == '0 || upper == '1)
        begin
            r = se[POS_WIDTH-1:0];
        end
        else if (se[EXT_W-1])
        begin
            r = {1'b1, {(POS_WIDTH - 1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(POS_WIDTH - 1){1'b1}}};
        end
        return r;
    endfunction

    // Sign and magnitude of the samples; walk length and restart.
    assign mag_m   = sample.gauss_mag[SAMPLE_WIDTH-1]   ? (~sample.gauss_mag + 1'b1)
                                                         : sample.gauss_mag;
    assign mag_x   = sample.gauss_dir_x[SAMPLE_WIDTH-1] ? (~sample.gauss_dir_x + 1'b1)
                                                         : sample.gauss_dir_x;
    assign mag_y   = sample.gauss_dir_y[SAMPLE_WIDTH-1] ? (~sample.gauss_dir_y + 1'b1)
                                                         : sample.gauss_dir_y;
    assign walk    = (num_steps < STEPS_W'(2)) ? STEPS_W'(1) : (num_steps - STEPS_W'(1));
    assign restart = (step_cnt_reg >= walk);
    assign cnt_new = restart ? STEPS_W'(1) : (step_cnt_reg + STEPS_W'(1));

    // Normalization status: the larger magnitude has its top bit at bit 14.
    assign norm_or        = na_reg | nb_reg;
    assign stat.zero_dir  = zero_reg;
    assign stat.norm_done = (norm_or[NORM_W-1:MAG_W] == '0) && norm_or[MAG_W-1];

    // Squared norm and the step length before direction.
    assign rad_sum    = RAD_SUM_W'(na_reg[MAG_W-1:0] * na_reg[MAG_W-1:0])
                      + RAD_SUM_W'(nb_reg[MAG_W-1:0] * nb_reg[MAG_W-1:0]);
    assign scale_prod = step_scale * mm_reg;

    // One square root digit per cycle.
    assign root_sh    = {root_rem_reg[ROOT_REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign root_trial = {1'b0, root_reg, 2'b01};
    assign root_fit   = (root_sh >= root_trial);

    // Dividends with the half divisor for rounding.
    assign num_x = (NUM_W'(na_reg[MAG_W-1:0]) << UNIT_SHIFT) + NUM_W'(root_reg >> 1);
    assign num_y = (NUM_W'(nb_reg[MAG_W-1:0]) << UNIT_SHIFT) + NUM_W'(root_reg >> 1);

    // One quotient bit per cycle for both components.
    assign div_den  = {1'b0, root_reg};
    assign div_sh_x = {rem_x_reg, quot_x_reg[QUOT_W-1]};
    assign div_sh_y = {rem_y_reg, quot_y_reg[QUOT_W-1]};
    assign fit_x    = (div_sh_x >= div_den);
    assign fit_y    = (div_sh_y >= div_den);

    // Shared multiplier for the two displacement components, then rounding.
    assign mul_b     = cmd.mul_y ? quot_y_reg : quot_x_reg;
    assign prod_next = s_reg * mul_b;
    assign rnd_sum   = {1'b0, prod_reg} + RND_HALF;

    // Position magnitudes for the distance.
    assign neg_x     = ~cur_x_reg + 1'b1;
    assign neg_y     = ~cur_y_reg + 1'b1;
    assign abs_x     = cur_x_reg[POS_WIDTH-1] ? neg_x : cur_x_reg;
    assign abs_y     = cur_y_reg[POS_WIDTH-1] ? neg_y : cur_y_reg;
    assign abs_x_ext = ABS_W'(abs_x);
    assign abs_y_ext = ABS_W'(abs_y);

    // Shared squarer and the clamped sum.
    assign sq_op   = cmd.sq_y ? ay_reg : ax_reg;
    assign sq_prod = sq_op * sq_op;
    assign dsq_sum = {1'b0, acc_reg} + {1'b0, sq_reg};

    assign result = result_reg;

    // Walk state: position and step count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            step_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                step_cnt_reg <= cnt_new;
                if (restart)
                begin
                    cur_x_reg <= '0;
                    cur_y_reg <= '0;
                end
            end
            if (cmd.pos_upd)
            begin
                cur_x_reg <= sat_add(cur_x_reg, dx_reg, mneg_reg ^ xneg_reg);
                cur_y_reg <= sat_add(cur_y_reg, dy_reg, mneg_reg ^ yneg_reg);
            end
        end
    end

    // Working registers of one item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mm_reg   <= mag_m;
            na_reg   <= NORM_W'(mag_x);
            nb_reg   <= NORM_W'(mag_y);
            mneg_reg <= sample.gauss_mag[SAMPLE_WIDTH-1];
            xneg_reg <= sample.gauss_dir_x[SAMPLE_WIDTH-1];
            yneg_reg <= sample.gauss_dir_y[SAMPLE_WIDTH-1];
            zero_reg <= (mag_x == '0) && (mag_y == '0);
            last_reg <= (cnt_new >= walk);
        end

        // Shift both direction magnitudes by one place toward the target range.
        if (cmd.norm_shift)
        begin
            if (norm_or[NORM_W-1:MAG_W] != '0)
            begin
                na_reg <= na_reg >> 1;
                nb_reg <= nb_reg >> 1;
            end
            else
            begin
                na_reg <= na_reg << 1;
                nb_reg <= nb_reg << 1;
            end
        end

        if (cmd.sq_sum)
        begin
            rad_reg      <= {ROOT_BITS'(rad_sum), {ROOT_BITS{1'b0}}};
            root_rem_reg <= '0;
            root_reg     <= '0;
            s_reg        <= scale_prod[SCALED_W-1:0];
        end

        if (cmd.root_step)
        begin
            rad_reg      <= rad_reg << 2;
            root_rem_reg <= root_fit ? (root_sh - root_trial) : root_sh;
            root_reg     <= {root_reg[ROOT_BITS-2:0], root_fit};
        end

        if (cmd.div_init)
        begin
            rem_x_reg  <= DIV_REM_W'(num_x[NUM_W-1:QUOT_W]);
            rem_y_reg  <= DIV_REM_W'(num_y[NUM_W-1:QUOT_W]);
            quot_x_reg <= num_x[QUOT_W-1:0];
            quot_y_reg <= num_y[QUOT_W-1:0];
        end

        if (cmd.div_step)
        begin
            rem_x_reg  <= fit_x ? DIV_REM_W'(div_sh_x - div_den) : div_sh_x[DIV_REM_W-1:0];
            rem_y_reg  <= fit_y ? DIV_REM_W'(div_sh_y - div_den) : div_sh_y[DIV_REM_W-1:0];
            quot_x_reg <= {quot_x_reg[QUOT_W-2:0], fit_x};
            quot_y_reg <= {quot_y_reg[QUOT_W-2:0], fit_y};
        end

        if (cmd.mul_x || cmd.mul_y)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.mul_y)
        begin
            dx_reg <= rnd_sum[PROD_W:RND_SHIFT];
        end
        if (cmd.rnd_y)
        begin
            dy_reg <= rnd_sum[PROD_W:RND_SHIFT];
        end

        if (cmd.abs_calc)
        begin
            ax_reg  <= abs_x_ext[SQ_OP_W-1:0];
            ay_reg  <= abs_y_ext[SQ_OP_W-1:0];
            big_reg <= (abs_x_ext > ROOT_MAX) || (abs_y_ext > ROOT_MAX);
        end

        if (cmd.sq_x || cmd.sq_y)
        begin
            sq_reg <= sq_prod;
        end
        if (cmd.sq_y)
        begin
            acc_reg <= sq_reg;
        end

        if (cmd.disp_sum)
        begin
            if (big_reg || (dsq_sum > DSQ_TOP))
            begin
                disp_reg <= DSQ_TOP[DSQ_W-1:0];
            end
            else
            begin
                disp_reg <= dsq_sum[DSQ_W-1:0];
            end
        end

        // Output register.
        if (cmd.out_load)
        begin
            result_reg.pos_x      <= cur_x_reg;
            result_reg.pos_y      <= cur_y_reg;
            result_reg.disp_sq    <= disp_reg;
            result_reg.step_index <= step_cnt_reg;
            result_reg.last_step  <= last_reg;
            result_reg.no_move    <= zero_reg;
        end
    end

endmodule

// ===== rtl/core/random_walk_particle_step.sv =====
// The time from an accepted item to its result varies with the one-place-per-cycle
// direction normalization and with result back-pressure; a zero direction pair skips
// the square root, division and position update. One item at a time: the next item is
// taken only after the result of the last is registered.
// Reset puts the particle at the origin, step count zero, step_scale 4096, num_steps 100.
// Depends on rwps_pkg, rwps_ctrl and rwps_datapath.
module random_walk_particle_step (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rwps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rwps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_stall,
    input  rwps_pkg::rwps_in_t               sample,
    output logic                             result_valid,
    input  logic                             result_stall,
    output rwps_pkg::rwps_out_t              result
);
    import rwps_pkg::*;

    logic [SCALE_W-1:0] step_scale_reg;
    logic [STEPS_W-1:0] num_steps_reg;
    rwps_cmd_t          cmd;
    rwps_stat_t         stat;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_scale_reg <= STEP_SCALE_RST;
            num_steps_reg  <= NUM_STEPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SCALE: step_scale_reg <= cfg_data[SCALE_W-1:0];
                REG_NUM_STEPS:  num_steps_reg  <= cfg_data[STEPS_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer.
    rwps_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Arithmetic and walk state.
    rwps_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .sample     (sample),
        .step_scale (step_scale_reg),
        .num_steps  (num_steps_reg),
        .result     (result)
    );

endmodule

// ===== rtl/core/rwps_checker.sv =====
// Port-level checks of the random walk particle step block, bound to its top level.
// Depends on rwps_pkg and sees only the top-level ports.
module rwps_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                sample_valid,
    input logic                sample_stall,
    input logic                result_valid,
    input logic                result_stall,
    input rwps_pkg::rwps_out_t result
);
    import rwps_pkg::*;

    // An accepted item occupies the block, so the next cycle is stalled.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("item accepted while another is in progress");

    // A stalled result holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // Step indexes count from one.
    a_step_index: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.step_index != '0)
        else $error("step index zero");

    // The distance is zero exactly at the origin.
    a_disp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |->
            ((result.disp_sq == '0) == ((result.pos_x == '0) && (result.pos_y == '0))))
        else $error("squared distance disagrees with position");

    // A first step without a move leaves the particle at the origin.
    a_first_still: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.no_move && (result.step_index == STEPS_W'(1)) |->
            (result.pos_x == '0) && (result.pos_y == '0))
        else $error("first step without a move left the origin");

endmodule

bind random_walk_particle_step rwps_checker u_rwps_checker (.*);

// ===== tb/sv/walk_step_checker.sv =====
// Checker for the random walk particle step block: watches the register port and
// both item channels, predicts every result from its own walk state and compares.
// Depends on rwps_pkg for the payload types, widths and register codes.
module walk_step_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rwps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rwps_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             sample_valid,
    input  logic                             sample_stall,
    input  rwps_pkg::rwps_in_t               sample,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  rwps_pkg::rwps_out_t              result,
    output int                               mismatch_count,
    output int                               steps_in_flight
);
    import rwps_pkg::*;

    // Fraction bits of a unit direction component.
    localparam int UFRAC = 46 - SAMPLE_WIDTH;
    localparam longint POS_HI = (longint'(1) << (POS_WIDTH - 1)) - 1;
    localparam longint POS_LO = -POS_HI - 1;
    localparam longint unsigned DSQ_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint unsigned ROOT_LIMIT = 64'h0000_0000_B504_F333;

    // Shadow of the registers and of the particle.
    logic [SCALE_W-1:0] scale_r;
    logic [STEPS_W-1:0] steps_r;
    longint             px;
    longint             py;
    int                 walk_pos;

    // Predicted steps waiting for the block to deliver them.
    rwps_out_t          step_expect[$];
    int                 errs;
    int                 seen;

    // Sign and magnitude of one sample.
    function automatic longint unsigned sample_mag(input logic [SAMPLE_WIDTH-1:0] v,
                                                   output bit neg);
        logic [SAMPLE_WIDTH-1:0] t;
        neg = v[SAMPLE_WIDTH-1];
        t = neg ? (~v + 1'b1) : v;
        return 64'(t);
    endfunction

    // Integer square root, one result bit per pass.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem = n;
        res = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Signed add of a displacement, clamped to the position width.
    function automatic longint pos_clamp(input longint p, input longint unsigned mag,
                                         input bit neg);
        longint d;
        longint v;
        d = neg ? -longint'(mag) : longint'(mag);
        v = p + d;
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return v;
    endfunction

    // Advance the shadow particle by one item and build the result it must give.
    function automatic rwps_out_t predict_step(input rwps_in_t it);
        rwps_out_t       o;
        bit              mneg;
        bit              xneg;
        bit              yneg;
        bit              still;
        longint unsigned mm;
        longint unsigned a;
        longint unsigned b;
        longint unsigned m;
        longint unsigned r;
        longint unsigned ux;
        longint unsigned uy;
        longint unsigned s;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sq;
        int              walk;
        mm = sample_mag(it.gauss_mag, mneg);
        a = sample_mag(it.gauss_dir_x, xneg);
        b = sample_mag(it.gauss_dir_y, yneg);
        walk = (steps_r < 2) ? 1 : int'(steps_r) - 1;

        // A finished walk starts over from the origin.
        if (walk_pos >= walk)
        begin
            px = 0;
            py = 0;
            walk_pos = 0;
        end
        walk_pos++;

        still = (a == 0) && (b == 0);
        if (!still)
        begin
            // Bring the larger direction magnitude into [2^14, 2^15).
            m = (a > b) ? a : b;
            while (m >= 64'd32768)
            begin
                a = a >> 1;
                b = b >> 1;
                m = m >> 1;
            end
            while (m < 64'd16384)
            begin
                a = a << 1;
                b = b << 1;
                m = m << 1;
            end
            r = int_sqrt((a * a + b * b) << 32);
            ux = ((a << (16 + UFRAC)) + (r >> 1)) / r;
            uy = ((b << (16 + UFRAC)) + (r >> 1)) / r;
            s = 64'(scale_r) * mm;
            ux = (s * ux + (64'd1 << (11 + UFRAC))) >> (12 + UFRAC);
            uy = (s * uy + (64'd1 << (11 + UFRAC))) >> (12 + UFRAC);
            px = pos_clamp(px, ux, mneg != xneg);
            py = pos_clamp(py, uy, mneg != yneg);
        end

        // Squared distance, saturated to 63 bits.
        ax = (px < 0) ? -px : px;
        ay = (py < 0) ? -py : py;
        if (ax > ROOT_LIMIT || ay > ROOT_LIMIT)
        begin
            sq = DSQ_MAX;
        end
        else
        begin
            sq = ax * ax + ay * ay;
            if (sq > DSQ_MAX)
                sq = DSQ_MAX;
        end

        o.pos_x = px[POS_WIDTH-1:0];
        o.pos_y = py[POS_WIDTH-1:0];
        o.disp_sq = sq[DSQ_W-1:0];
        o.step_index = STEPS_W'(walk_pos);
        o.last_step = (walk_pos >= walk);
        o.no_move = still;
        return o;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        errs++;
        $display("result %0d %s: got 0x%0h, expected 0x%0h", seen, field, got, want);
    endtask

    // Field by field comparison of one delivered step.
    task automatic compare_step(input rwps_out_t got, input rwps_out_t want);
        if (got.pos_x !== want.pos_x)
            report_mismatch("pos_x", got.pos_x, want.pos_x);
        if (got.pos_y !== want.pos_y)
            report_mismatch("pos_y", got.pos_y, want.pos_y);
        if (got.disp_sq !== want.disp_sq)
            report_mismatch("disp_sq", got.disp_sq, want.disp_sq);
        if (got.step_index !== want.step_index)
            report_mismatch("step_index", got.step_index, want.step_index);
        if (got.last_step !== want.last_step)
            report_mismatch("last_step", got.last_step, want.last_step);
        if (got.no_move !== want.no_move)
            report_mismatch("no_move", got.no_move, want.no_move);
    endtask

    // Track register writes, predict accepted items and check accepted results.
    always @(posedge clk or negedge rst_n)
    begin
        rwps_out_t want;
        if (!rst_n)
        begin
            scale_r = STEP_SCALE_RST;
            steps_r = NUM_STEPS_RST;
            px = 0;
            py = 0;
            walk_pos = 0;
            step_expect.delete();
            errs = 0;
            seen = 0;
            mismatch_count <= 0;
            steps_in_flight <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_STEP_SCALE)
                    scale_r = cfg_data[SCALE_W-1:0];
                else if (cfg_index == REG_NUM_STEPS)
                    steps_r = cfg_data[STEPS_W-1:0];
            end
            if (sample_valid && !sample_stall)
            begin
                want = predict_step(sample);
                step_expect.insert(step_expect.size(), want);
            end
            if (result_valid && !result_stall)
            begin
                seen++;
                if (step_expect.size() == 0)
                begin
                    report_mismatch("unexpected result, step_index", result.step_index, 0);
                end
                else
                begin
                    want = step_expect.pop_front();
                    compare_step(result, want);
                end
            end
            mismatch_count <= errs;
            steps_in_flight <= step_expect.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// Top of the random walk particle step testbench: clock, reset, register writes,
// sample stimulus and result back-pressure, with the verdict at the end.
// Depends on rwps_pkg, random_walk_particle_step and walk_step_checker.
module tb;
    import rwps_pkg::*;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_STEP_SCALE;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    rwps_in_t               sample = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    rwps_out_t              result;
    int                     mismatch_count;
    int                     steps_in_flight;
    // Random idling of both sides; cleared for one long stretch.
    bit                     idle_en = 1'b1;

    random_walk_particle_step dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    walk_step_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .sample_valid    (sample_valid),
        .sample_stall    (sample_stall),
        .sample          (sample),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .steps_in_flight (steps_in_flight)
    );

    // Clock with a period of 10.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin
        #100_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Result back-pressure: a random stall about 12 percent of the time while idling is on.
    always @(posedge clk)
    begin
        result_stall <= idle_en && ($urandom_range(0, 99) < 12);
    end

    // Build one item from three integers.
    function automatic rwps_in_t pack_sample(input int m, input int x, input int y);
        rwps_in_t s;
        s.gauss_mag = SAMPLE_WIDTH'(m);
        s.gauss_dir_x = SAMPLE_WIDTH'(x);
        s.gauss_dir_y = SAMPLE_WIDTH'(y);
        return s;
    endfunction

    // A random item: mostly normal-looking samples, plus raw bits, zero directions, zero magnitudes and corner cases.
    function automatic rwps_in_t random_sample();
        int kind;
        int corner[5];
        corner = '{-32768, 32767, 0, 1, -1};
        kind = $urandom_range(0, 99);
        if (kind < 55)
            return pack_sample(int'($urandom_range(0, 24575)) - 12288,
                               int'($urandom_range(0, 24575)) - 12288,
                               int'($urandom_range(0, 24575)) - 12288);
        if (kind < 78)
            return pack_sample($urandom, $urandom, $urandom);
        if (kind < 86)
            return pack_sample($urandom, 0, 0);
        if (kind < 92)
            return pack_sample(0, $urandom, $urandom);
        return pack_sample(corner[$urandom_range(0, 4)], corner[$urandom_range(0, 4)],
                           corner[$urandom_range(0, 4)]);
    endfunction

    // Offer one item and return at the edge that accepts it.
    task automatic send(input rwps_in_t it);
        if (idle_en && $urandom_range(0, 99) < 12)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge clk);
        end
        sample <= it;
        sample_valid <= 1'b1;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
    endtask

    // Stop offering items and wait until every predicted step has come back.
    task automatic settle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (steps_in_flight != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both registers while the block is idle.
    task automatic set_config(input logic [CFG_DATA_W-1:0] scale,
                              input logic [CFG_DATA_W-1:0] steps);
        cfg_we <= 1'b1;
        cfg_index <= REG_STEP_SCALE;
        cfg_data <= scale;
        @(posedge clk);
        cfg_index <= REG_NUM_STEPS;
        cfg_data <= steps;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus.
    initial
    begin
        int seg;
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items under the reset settings.
        send(pack_sample(4096, 4096, 0));
        send(pack_sample(4096, 0, 0));
        send(pack_sample(0, 100, 200));
        send(pack_sample(-32768, -32768, -32768));
        send(pack_sample(32767, 32767, 32767));
        send(pack_sample(32767, -32768, 32767));
        send(pack_sample(-32768, 1, 0));
        send(pack_sample(1, 0, -1));
        send(pack_sample(-1, -1, -1));
        send(pack_sample(12345, 32767, 1));
        send(pack_sample(32767, 0, -32768));
        send(pack_sample(16'h5555, 16'hAAAA, 16'h5555));
        settle();

        // Zero scale: every step has zero length.
        set_config(16'd0, 16'd100);
        repeat (3) send(random_sample());
        settle();

        // Largest scale with the shortest legal walk: every step is a last step.
        set_config(16'hFFFF, 16'd2);
        send(pack_sample(32767, 32767, -32768));
        send(pack_sample(-32768, 16'hAAAA, 16'h5555));
        send(pack_sample(4096, 0, 0));
        settle();

        // Walk lengths below two behave as one-step walks.
        set_config(16'd4096, 16'd1);
        repeat (3) send(random_sample());
        settle();
        set_config(16'd4096, 16'd0);
        repeat (3) send(random_sample());
        settle();

        // Random items over several settings; one segment has no idling at all.
        for (seg = 0; seg < 6; seg++)
        begin
            idle_en <= (seg != 2);
            case (seg)
                0: set_config(16'd4096, 16'd100);
                1: set_config(16'hFFFF, 16'd3);
                2: set_config(16'($urandom), 16'($urandom_range(2, 12)));
                3: set_config(16'd1, 16'hFFFF);
                4: set_config(16'($urandom), 16'd2);
                default: set_config(16'($urandom), 16'($urandom_range(2, 40)));
            endcase
            for (i = 0; i < 165; i++)
                send(random_sample());
            settle();
        end

        // A run of full-length steps toward the negative corner in one long walk.
        set_config(16'hFFFF, 16'hFFFF);
        for (i = 0; i < 20; i++)
            send(pack_sample(32767, -32768, -32768));
        settle();

        // Shortening the walk below the steps already taken forces a restart.
        set_config(16'd4096, 16'd2);
        for (i = 0; i < 10; i++)
            send(random_sample());

        // Drain, let the block sit a while, then give the verdict.
        sample_valid <= 1'b0;
        @(posedge clk);
        while (steps_in_flight != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && steps_in_flight == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== random_walk_particle_step.f =====
rtl/core/rwps_pkg.sv
rtl/core/rwps_ctrl.sv
rtl/core/rwps_datapath.sv
rtl/core/random_walk_particle_step.sv
rtl/core/rwps_checker.sv
tb/sv/walk_step_checker.sv
tb/sv/tb.sv
